// ===== sv/go_back_n_sender_window_defines.svh =====
// ----------------------------------------------------------------------------
// Go-back-N sender window: assertion macros
// Shared macros for the concurrent checks on the sender window ports.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Check that is switched off while reset is asserted
`define GBN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also holds while reset is asserted
`define GBN_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Field widths and code values shared by the sender window and its checker.
// ----------------------------------------------------------------------------
package gbn_pkg;

   // Field widths
   localparam int OP_W     = 2;
   localparam int HANDLE_W = 10;
   localparam int SEQ_W    = 8;
   localparam int LIMIT_W  = 4;
   localparam int TIMER_W  = 2;

   // Window limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   // Operation codes
   localparam logic [OP_W-1:0] OP_QUEUE   = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
   localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

   // Timer action codes
   localparam logic [TIMER_W-1:0] TMR_LEAVE = 2'd0;
   localparam logic [TIMER_W-1:0] TMR_START = 2'd1;
   localparam logic [TIMER_W-1:0] TMR_STOP  = 2'd2;

endpackage

// ===== sv/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/go_back_n_sender_window.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-back-N sender window: packet queue, cumulative acks, timeout resends.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A queue item or a good
// acknowledgement sends N packets, N being at most the window limit; a timeout
// resends the F packets in flight. A bad-checksum ack, an unused operation code
// or a timeout with nothing in flight gives one empty result from idle. Each
// packet passes the registered read of the pending-queue or slot memory, one
// packet per cycle, and then the output register. Results leave at one per
// cycle with no gaps inside an item, each on the rsp_ ports for exactly one
// cycle with rsp_strobe high; the receiver cannot stall them, so it must take
// every beat. The user must write window_limit through csr_we/csr_wdata only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
   parameter int WINDOW_SIZE   = 8,
   parameter int SEQ_MODULUS   = 16,
   parameter int PENDING_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [gbn_pkg::OP_W-1:0]         req_operation,
   input  logic [gbn_pkg::HANDLE_W-1:0]     req_packet_handle,
   input  logic [gbn_pkg::SEQ_W-1:0]        req_ack_number,
   input  logic                             req_checksum_ok,
   // result channel
   output logic                             rsp_strobe,
   output logic                             rsp_send_valid,
   output logic [gbn_pkg::HANDLE_W-1:0]     rsp_send_handle,
   output logic [gbn_pkg::SEQ_W-1:0]        rsp_send_seq,
   output logic                             rsp_is_retransmit,
   output logic [gbn_pkg::TIMER_W-1:0]      rsp_timer_action,
   output logic                             rsp_dropped_full,
   output logic                             rsp_last,
   // configuration
   input  logic                             csr_we,
   input  logic [gbn_pkg::LIMIT_W-1:0]      csr_wdata
);

   // Derived sizes
   localparam int LIM_CAP = (WINDOW_SIZE < SEQ_MODULUS - 1) ? WINDOW_SIZE : SEQ_MODULUS - 1;
   localparam int IF_W    = $clog2(LIM_CAP + 1);
   localparam int SLOT_AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int PQ_AW   = $clog2(PENDING_DEPTH);
   localparam int PQ_CW   = $clog2(PENDING_DEPTH + 1);
   localparam int MOD_W   = gbn_pkg::SEQ_W + 1;
   localparam int HW      = gbn_pkg::HANDLE_W;
   localparam int SW      = gbn_pkg::SEQ_W;

   localparam logic [MOD_W-1:0]   MOD_C   = MOD_W'(SEQ_MODULUS);
   localparam logic [MOD_W-1:0]   CAP_C   = MOD_W'(LIM_CAP);
   localparam logic [SLOT_AW:0]   WIN_C   = (SLOT_AW + 1)'(WINDOW_SIZE);
   localparam logic [PQ_AW-1:0]   PQ_LAST = PQ_AW'(PENDING_DEPTH - 1);
   localparam logic [PQ_CW-1:0]   PQ_FULL = PQ_CW'(PENDING_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND,
      ST_RETX
   } state_type;

   // Sequence number plus offset, modulo SEQ_MODULUS (sum stays below twice it)
   function automatic logic [SW-1:0] seq_add(input logic [SW-1:0] base,
                                             input logic [MOD_W-1:0] k);
      logic [MOD_W-1:0] sum;
      sum = {1'b0, base} + k;
      if (sum >= MOD_C) begin
         sum = sum - MOD_C;
      end
      return sum[SW-1:0];
   endfunction

   // Slot ring index plus offset, modulo WINDOW_SIZE
   function automatic logic [SLOT_AW-1:0] slot_add(input logic [SLOT_AW-1:0] base,
                                                   input logic [IF_W-1:0] k);
      logic [SLOT_AW:0] sum;
      sum = (SLOT_AW + 1)'(base) + (SLOT_AW + 1)'(k);
      if (sum >= WIN_C) begin
         sum = sum - WIN_C;
      end
      return sum[SLOT_AW-1:0];
   endfunction

   // Control state
   state_type                     state_ff, state_in;
   logic [gbn_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic [SW-1:0]                 base_ff, base_in;
   logic [SW-1:0]                 nseq_ff, nseq_in;
   logic [IF_W-1:0]               infl_ff, infl_in;
   logic [SLOT_AW-1:0]            sbase_ff, sbase_in;
   logic [PQ_AW-1:0]              head_ff, head_in;
   logic [PQ_AW-1:0]              tail_ff, tail_in;
   logic [PQ_CW-1:0]              cnt_ff, cnt_in;
   logic [IF_W-1:0]               idx_ff, idx_in;
   logic                          freed_ff, freed_in;
   logic                          empty0_ff, empty0_in;
   logic                          drop_ff, drop_in;

   // Memory read stage
   logic                          stg_vld_ff, stg_vld_in;
   logic                          stg_retx_ff, stg_retx_in;
   logic [SW-1:0]                 stg_seq_ff, stg_seq_in;
   logic [SLOT_AW-1:0]            stg_slot_ff, stg_slot_in;
   logic                          stg_last_ff, stg_last_in;
   logic [gbn_pkg::TIMER_W-1:0]   stg_timer_ff, stg_timer_in;
   logic                          stg_drop_ff, stg_drop_in;

   // Result register
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]                 rsp_handle_ff, rsp_handle_in;
   logic [SW-1:0]                 rsp_seq_ff, rsp_seq_in;
   logic                          rsp_retx_ff, rsp_retx_in;
   logic [gbn_pkg::TIMER_W-1:0]   rsp_timer_ff, rsp_timer_in;
   logic                          rsp_drop_ff, rsp_drop_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Memory ports
   logic                          pq_we, pq_re;
   logic [HW-1:0]                 pq_rdata;
   logic                          slot_we, slot_re;
   logic [SLOT_AW-1:0]            slot_raddr;
   logic [HW-1:0]                 slot_rdata;

   // Window arithmetic
   logic                          accept;
   logic [MOD_W-1:0]              lim_raw, lim_eff, infl_x, ack_x, dist_raw, ack_dist, freed;
   logic                          ack_hit, can_send, more_after;
   logic [IF_W-1:0]               infl_after_ack;

   assign busy   = (state_ff != ST_IDLE) || stg_vld_ff;
   assign accept = start && !busy;

   // Effective window limit: zero acts as one, capped at the window size and at the modulus minus one
   always_comb begin
      lim_raw = MOD_W'(limit_ff);
      lim_eff = lim_raw;
      if (lim_raw == '0) begin
         lim_eff = MOD_W'(1);
      end else if (lim_raw > CAP_C) begin
         lim_eff = CAP_C;
      end
   end

   assign infl_x     = MOD_W'(infl_ff);
   assign can_send   = (infl_x < lim_eff) && (cnt_ff != '0);
   assign more_after = ((infl_x + MOD_W'(1)) < lim_eff) && (cnt_ff > PQ_CW'(1));

   // Cumulative ack: circular distance from the window base
   assign ack_x    = {1'b0, req_ack_number};
   assign dist_raw = ack_x + MOD_C - {1'b0, base_ff};
   assign ack_dist = (dist_raw >= MOD_C) ? dist_raw - MOD_C : dist_raw;
   assign ack_hit  = (ack_x < MOD_C) && (ack_dist < infl_x);
   assign freed    = ack_dist + MOD_W'(1);
   assign infl_after_ack = infl_ff - IF_W'(freed);

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      base_in      = base_ff;
      nseq_in      = nseq_ff;
      infl_in      = infl_ff;
      sbase_in     = sbase_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      freed_in     = freed_ff;
      empty0_in    = empty0_ff;
      drop_in      = drop_ff;

      stg_vld_in   = 1'b0;
      stg_retx_in  = stg_retx_ff;
      stg_seq_in   = stg_seq_ff;
      stg_slot_in  = stg_slot_ff;
      stg_last_in  = stg_last_ff;
      stg_timer_in = stg_timer_ff;
      stg_drop_in  = stg_drop_ff;

      rsp_strobe_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_retx_in   = rsp_retx_ff;
      rsp_timer_in  = rsp_timer_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_last_in   = rsp_last_ff;

      pq_we      = 1'b0;
      pq_re      = 1'b0;
      slot_re    = 1'b0;
      slot_raddr = slot_add(sbase_ff, idx_ff);

      if (csr_we) begin
         limit_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Default: a lone empty result that closes the item
               rsp_valid_in  = 1'b0;
               rsp_handle_in = '0;
               rsp_seq_in    = '0;
               rsp_retx_in   = 1'b0;
               rsp_timer_in  = gbn_pkg::TMR_LEAVE;
               rsp_drop_in   = 1'b0;
               rsp_last_in   = 1'b1;
               unique case (req_operation)
                  gbn_pkg::OP_QUEUE: begin
                     freed_in  = 1'b0;
                     empty0_in = (infl_ff == '0);
                     if (cnt_ff == PQ_FULL) begin
                        drop_in = 1'b1;
                     end else begin
                        drop_in = 1'b0;
                        pq_we   = 1'b1;
                        tail_in = (tail_ff == PQ_LAST) ? '0 : tail_ff + PQ_AW'(1);
                        cnt_in  = cnt_ff + PQ_CW'(1);
                     end
                     state_in = ST_SEND;
                  end
                  gbn_pkg::OP_ACK: begin
                     if (req_checksum_ok) begin
                        drop_in  = 1'b0;
                        freed_in = ack_hit;
                        if (ack_hit) begin
                           infl_in   = infl_after_ack;
                           base_in   = seq_add(req_ack_number, MOD_W'(1));
                           sbase_in  = slot_add(sbase_ff, IF_W'(freed));
                           empty0_in = (infl_after_ack == '0);
                        end else begin
                           empty0_in = (infl_ff == '0);
                        end
                        state_in = ST_SEND;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  gbn_pkg::OP_TIMEOUT: begin
                     if (infl_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_RETX;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SEND: begin
            if (can_send) begin
               // Pop the queue head; its handle arrives next cycle
               pq_re        = 1'b1;
               head_in      = (head_ff == PQ_LAST) ? '0 : head_ff + PQ_AW'(1);
               cnt_in       = cnt_ff - PQ_CW'(1);
               infl_in      = infl_ff + IF_W'(1);
               nseq_in      = seq_add(nseq_ff, MOD_W'(1));
               stg_vld_in   = 1'b1;
               stg_retx_in  = 1'b0;
               stg_seq_in   = nseq_ff;
               stg_slot_in  = slot_add(sbase_ff, infl_ff);
               stg_last_in  = !more_after;
               stg_timer_in = (!more_after && (freed_ff || empty0_ff)) ?
                              gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE;
               stg_drop_in  = !more_after && drop_ff;
               if (!more_after) begin
                  state_in = ST_IDLE;
               end
            end else begin
               // Nothing to send: one empty closing result
               rsp_strobe_in = 1'b1;
               rsp_valid_in  = 1'b0;
               rsp_handle_in = '0;
               rsp_seq_in    = '0;
               rsp_retx_in   = 1'b0;
               rsp_drop_in   = drop_ff;
               rsp_last_in   = 1'b1;
               if (freed_ff) begin
                  rsp_timer_in = (infl_ff == '0) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_START;
               end else begin
                  rsp_timer_in = gbn_pkg::TMR_LEAVE;
               end
               state_in = ST_IDLE;
            end
         end

         ST_RETX: begin
            // Resend frames in flight, oldest first
            slot_re      = 1'b1;
            stg_vld_in   = 1'b1;
            stg_retx_in  = 1'b1;
            stg_seq_in   = seq_add(base_ff, MOD_W'(idx_ff));
            stg_last_in  = (idx_ff == infl_ff - IF_W'(1));
            stg_timer_in = (idx_ff == infl_ff - IF_W'(1)) ?
                           gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE;
            stg_drop_in  = 1'b0;
            idx_in       = idx_ff + IF_W'(1);
            if (idx_ff == infl_ff - IF_W'(1)) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Read stage: memory data is back, build the send beat
      if (stg_vld_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_handle_in = stg_retx_ff ? slot_rdata : pq_rdata;
         rsp_seq_in    = stg_seq_ff;
         rsp_retx_in   = stg_retx_ff;
         rsp_timer_in  = stg_timer_ff;
         rsp_drop_in   = stg_drop_ff;
         rsp_last_in   = stg_last_ff;
      end
   end

   // New sends record their handle in the slot ring
   assign slot_we = stg_vld_ff && !stg_retx_ff;

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= gbn_pkg::LIMIT_RESET;
         base_ff       <= '0;
         nseq_ff       <= '0;
         infl_ff       <= '0;
         sbase_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         cnt_ff        <= '0;
         stg_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         base_ff       <= base_in;
         nseq_ff       <= nseq_in;
         infl_ff       <= infl_in;
         sbase_ff      <= sbase_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
         stg_vld_ff    <= stg_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff        <= idx_in;
      freed_ff      <= freed_in;
      empty0_ff     <= empty0_in;
      drop_ff       <= drop_in;
      stg_retx_ff   <= stg_retx_in;
      stg_seq_ff    <= stg_seq_in;
      stg_slot_ff   <= stg_slot_in;
      stg_last_ff   <= stg_last_in;
      stg_timer_ff  <= stg_timer_in;
      stg_drop_ff   <= stg_drop_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_retx_ff   <= rsp_retx_in;
      rsp_timer_ff  <= rsp_timer_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Pending packet queue
   gbn_ram #(
      .WIDTH (HW),
      .DEPTH (PENDING_DEPTH)
   ) u_pending_ram (
      .clock   (clock),
      .wr_en   (pq_we),
      .wr_addr (tail_ff),
      .wr_data (req_packet_handle),
      .rd_en   (pq_re),
      .rd_addr (head_ff),
      .rd_data (pq_rdata)
   );

   // Handles of frames in flight, ring indexed from the slot base
   gbn_ram #(
      .WIDTH (HW),
      .DEPTH (WINDOW_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (stg_slot_ff),
      .wr_data (pq_rdata),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_send_valid    = rsp_valid_ff;
   assign rsp_send_handle   = rsp_handle_ff;
   assign rsp_send_seq      = rsp_seq_ff;
   assign rsp_is_retransmit = rsp_retx_ff;
   assign rsp_timer_action  = rsp_timer_ff;
   assign rsp_dropped_full  = rsp_drop_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== sv/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the sender window result stream, bound to the top.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_window_defines.svh"

module gbn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             busy,
   input logic                             rsp_strobe,
   input logic                             rsp_send_valid,
   input logic [gbn_pkg::TIMER_W-1:0]      rsp_timer_action,
   input logic                             rsp_dropped_full,
   input logic                             rsp_last
);

   // Timer action or drop flag raised on this beat
   logic flags_set;
   assign flags_set = (rsp_timer_action != gbn_pkg::TMR_LEAVE) || rsp_dropped_full;

   // Beats of one item come back to back
   `GBN_ASSERT(a_beats_contiguous, rsp_strobe && !rsp_last |=> rsp_strobe, "gap inside an item")

   // More beats to come means the block is still occupied
   `GBN_ASSERT(a_busy_midstream, rsp_strobe && !rsp_last |-> busy, "not busy between beats")

   // An empty beat is always the only one of its item
   `GBN_ASSERT(a_empty_is_last, rsp_strobe && !rsp_send_valid |-> rsp_last, "empty beat not last")

   // Timer action and drop flag only on the closing beat
   `GBN_ASSERT(a_flags_on_last, rsp_strobe && flags_set |-> rsp_last, "flags on non-final beat")

   // No result in the cycle after a reset edge
   `GBN_ASSERT_ALWAYS(a_quiet_after_reset, reset |=> !rsp_strobe, "beat after reset")

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);

// ===== tb/sv/go_back_n_sender_window_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_test
// Self-checking bench for the go-back-N sender window. It drives queue, ack
// and timeout events through the start/busy port and keeps its own copy of
// the window and the pending backlog to work out every send beat. Each beat
// on the rsp_ ports is compared with the oldest outstanding one, field by field.
// The window limit is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_test;

   localparam int WINDOW_SIZE   = 8;
   localparam int SEQ_MODULUS   = 16;
   localparam int PENDING_DEPTH = 16;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int DUE_DEPTH     = 64;

   // code the block treats as a no-op
   localparam logic [gbn_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                         send_valid;
      logic [gbn_pkg::HANDLE_W-1:0] handle;
      logic [gbn_pkg::SEQ_W-1:0]    seq;
      logic                         retx;
      logic [gbn_pkg::TIMER_W-1:0]  timer;
      logic                         dropped;
      logic                         last;
   } tx_beat_type;

   // DUT ports, all inputs known from time zero
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [gbn_pkg::OP_W-1:0]     req_operation = gbn_pkg::OP_QUEUE;
   logic [gbn_pkg::HANDLE_W-1:0] req_packet_handle = '0;
   logic [gbn_pkg::SEQ_W-1:0]    req_ack_number = '0;
   logic                         req_checksum_ok = 1'b0;
   logic                         rsp_strobe;
   logic                         rsp_send_valid;
   logic [gbn_pkg::HANDLE_W-1:0] rsp_send_handle;
   logic [gbn_pkg::SEQ_W-1:0]    rsp_send_seq;
   logic                         rsp_is_retransmit;
   logic [gbn_pkg::TIMER_W-1:0]  rsp_timer_action;
   logic                         rsp_dropped_full;
   logic                         rsp_last;
   logic                         csr_we = 1'b0;
   logic [gbn_pkg::LIMIT_W-1:0]  csr_wdata = '0;

   // expected window state
   logic [gbn_pkg::LIMIT_W-1:0]  win_limit_reg = gbn_pkg::LIMIT_RESET;
   logic [gbn_pkg::SEQ_W-1:0]    win_base = '0;
   logic [gbn_pkg::SEQ_W-1:0]    win_next = '0;
   logic [3:0]                   win_count = '0;
   logic [gbn_pkg::HANDLE_W-1:0] win_handles [WINDOW_SIZE];
   logic [gbn_pkg::HANDLE_W-1:0] backlog [PENDING_DEPTH];
   logic [4:0]                   backlog_count = '0;
   logic [3:0]                   backlog_head = '0;

   // beats of the current event, and the ring of beats still due
   tx_beat_type item_beats [WINDOW_SIZE + 1];
   int          item_count = 0;
   tx_beat_type due_beats [DUE_DEPTH];
   int          due_wr = 0;
   int          due_rd = 0;
   tx_beat_type seen_beat;
   tx_beat_type want_beat;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   go_back_n_sender_window #(
      .WINDOW_SIZE   (WINDOW_SIZE),
      .SEQ_MODULUS   (SEQ_MODULUS),
      .PENDING_DEPTH (PENDING_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_packet_handle (req_packet_handle),
      .req_ack_number    (req_ack_number),
      .req_checksum_ok   (req_checksum_ok),
      .rsp_strobe        (rsp_strobe),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_send_handle   (rsp_send_handle),
      .rsp_send_seq      (rsp_send_seq),
      .rsp_is_retransmit (rsp_is_retransmit),
      .rsp_timer_action  (rsp_timer_action),
      .rsp_dropped_full  (rsp_dropped_full),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // append one beat to the current event
   function automatic void add_item_beat(input tx_beat_type b);
      item_beats[item_count] = b;
      item_count = item_count + 1;
   endfunction

   // hand one beat to the checker ring
   function automatic void post_due(input tx_beat_type b);
      due_beats[due_wr % DUE_DEPTH] = b;
      due_wr = due_wr + 1;
   endfunction

   // one beat as text for reports
   function automatic string beat_text(input tx_beat_type b);
      return $sformatf("valid=%0d handle=%0d seq=%0d retx=%0d timer=%0d drop=%0d last=%0d",
                       b.send_valid, b.handle, b.seq, b.retx, b.timer, b.dropped, b.last);
   endfunction

   // move backlog packets into the window while the limit allows
   function automatic void drain_backlog();
      int unsigned lim;
      logic [gbn_pkg::HANDLE_W-1:0] h;
      tx_beat_type b;
      lim = win_limit_reg;
      if (lim == 0) lim = 1;
      if (lim > WINDOW_SIZE) lim = WINDOW_SIZE;
      if (lim > SEQ_MODULUS - 1) lim = SEQ_MODULUS - 1;
      while (win_count < lim && backlog_count > 0) begin
         h = backlog[backlog_head];
         backlog_head = (backlog_head + 1) % PENDING_DEPTH;
         backlog_count = backlog_count - 1;
         win_handles[win_count % WINDOW_SIZE] = h;
         b = '0;
         b.send_valid = 1'b1;
         b.handle = h;
         b.seq = win_next;
         b.timer = gbn_pkg::TMR_LEAVE;
         add_item_beat(b);
         win_count = win_count + 1;
         win_next = (win_next + 1) % SEQ_MODULUS;
      end
   endfunction

   // advance the window for one accepted event and queue the beats it causes
   function automatic void apply_event(logic [gbn_pkg::OP_W-1:0] op,
                                       logic [gbn_pkg::HANDLE_W-1:0] h,
                                       logic [gbn_pkg::SEQ_W-1:0] ack, logic ok);
      int unsigned prior_count;
      int unsigned freed;
      int unsigned ack_dist;
      int unsigned i;
      logic [gbn_pkg::TIMER_W-1:0] timer;
      logic dropped;
      tx_beat_type b;
      item_count = 0;
      timer = gbn_pkg::TMR_LEAVE;
      dropped = 1'b0;
      case (op)
         gbn_pkg::OP_QUEUE: begin
            prior_count = win_count;
            if (backlog_count >= PENDING_DEPTH) begin
               dropped = 1'b1;
            end else begin
               backlog[(backlog_head + backlog_count) % PENDING_DEPTH] = h;
               backlog_count = backlog_count + 1;
            end
            drain_backlog();
            if (item_count > 0 && prior_count == 0) timer = gbn_pkg::TMR_START;
         end
         gbn_pkg::OP_ACK: begin
            if (ok) begin
               freed = 0;
               if (ack < SEQ_MODULUS) begin
                  ack_dist = (ack + SEQ_MODULUS - win_base) % SEQ_MODULUS;
                  if (ack_dist < win_count) freed = ack_dist + 1;
               end
               // cumulative ack: slide the remaining handles down
               if (freed > 0) begin
                  for (i = 0; i + freed < win_count; i++)
                     win_handles[i % WINDOW_SIZE] = win_handles[(i + freed) % WINDOW_SIZE];
                  win_count = win_count - freed;
                  win_base = (win_base + freed) % SEQ_MODULUS;
               end
               prior_count = win_count;
               drain_backlog();
               if (freed > 0)
                  timer = (win_count == 0) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_START;
               else if (item_count > 0 && prior_count == 0)
                  timer = gbn_pkg::TMR_START;
            end
         end
         gbn_pkg::OP_TIMEOUT: begin
            // go back N: resend everything in flight, oldest first
            for (i = 0; i < win_count && i < WINDOW_SIZE; i++) begin
               b = '0;
               b.send_valid = 1'b1;
               b.handle = win_handles[i];
               b.seq = 8'((win_base + i) % SEQ_MODULUS);
               b.retx = 1'b1;
               b.timer = gbn_pkg::TMR_LEAVE;
               add_item_beat(b);
            end
            if (win_count > 0) timer = gbn_pkg::TMR_START;
         end
         default: ;
      endcase
      if (item_count == 0) begin
         b = '0;
         add_item_beat(b);
      end
      b = item_beats[item_count - 1];
      b.timer = timer;
      b.dropped = dropped;
      b.last = 1'b1;
      item_beats[item_count - 1] = b;
      for (int k = 0; k < item_count; k++) post_due(item_beats[k]);
   endfunction

   // result checker: every strobe beat against the oldest outstanding one
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         seen_beat.send_valid = rsp_send_valid;
         seen_beat.handle     = rsp_send_handle;
         seen_beat.seq        = rsp_send_seq;
         seen_beat.retx       = rsp_is_retransmit;
         seen_beat.timer      = rsp_timer_action;
         seen_beat.dropped    = rsp_dropped_full;
         seen_beat.last       = rsp_last;
         if (due_wr == due_rd) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: %s", beat_text(seen_beat));
         end else begin
            want_beat = due_beats[due_rd % DUE_DEPTH];
            due_rd = due_rd + 1;
            if (seen_beat !== want_beat) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("beat mismatch: exp %s | got %s",
                           beat_text(want_beat), beat_text(seen_beat));
            end
         end
      end
   end

   // offer one event and hold it until the block takes it
   task automatic send_event(input logic [gbn_pkg::OP_W-1:0] op,
                             input logic [gbn_pkg::HANDLE_W-1:0] h,
                             input logic [gbn_pkg::SEQ_W-1:0] ack, input logic ok);
      req_operation     <= op;
      req_packet_handle <= h;
      req_ack_number    <= ack;
      req_checksum_ok   <= ok;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      apply_event(op, h, ack, ok);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait until every beat is in and the block is idle
   task automatic settle_idle();
      start <= 1'b0;
      @(posedge clock);
      while (due_wr != due_rd || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [gbn_pkg::LIMIT_W-1:0] value);
      settle_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      win_limit_reg = value;
   endtask

   // events that change nothing: empty timeout, unused code, bad checksum
   task automatic test_idle_events();
      send_event(gbn_pkg::OP_TIMEOUT, 10'd0, 8'd0, 1'b0);
      send_event(OP_UNUSED, 10'd1023, 8'd255, 1'b1);
      send_event(gbn_pkg::OP_ACK, 10'd1023, 8'd0, 1'b0);
   endtask

   // limit of zero behaves as one; out-of-range ack, timeout, ack to empty
   task automatic test_zero_limit();
      write_limit(4'd0);
      send_event(gbn_pkg::OP_QUEUE, 10'd0, 8'd0, 1'b0);
      send_event(gbn_pkg::OP_QUEUE, 10'd1023, 8'd255, 1'b1);
      send_event(gbn_pkg::OP_ACK, 10'd0, 8'd255, 1'b1);
      send_event(gbn_pkg::OP_ACK, 10'd0, 8'd0, 1'b1);
      send_event(gbn_pkg::OP_TIMEOUT, 10'd0, 8'd0, 1'b0);
      send_event(gbn_pkg::OP_ACK, 10'd0, 8'd1, 1'b1);
   endtask

   // one slot open: fill the backlog until a packet gets refused
   task automatic test_pending_overflow();
      write_limit(4'd1);
      for (int n = 0; n < PENDING_DEPTH + 2; n++)
         send_event(gbn_pkg::OP_QUEUE, 10'($urandom_range(1023)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
   endtask

   // mixed traffic: mostly in-window acks, some stray ones, timeouts, noise
   task automatic test_random_traffic(input logic [gbn_pkg::LIMIT_W-1:0] limit,
                                      input int beats_goal, input int queue_pct,
                                      input bit idle_on);
      int done;
      int pick;
      logic [gbn_pkg::OP_W-1:0] op;
      logic [gbn_pkg::HANDLE_W-1:0] h;
      logic [gbn_pkg::SEQ_W-1:0] ack;
      logic ok;
      write_limit(limit);
      done = 0;
      while (done < beats_goal) begin
         h   = 10'($urandom_range(1023));
         ack = 8'($urandom_range(255));
         ok  = 1'($urandom_range(1));
         if ($urandom_range(99) < queue_pct) begin
            op = gbn_pkg::OP_QUEUE;
         end else begin
            pick = $urandom_range(99);
            if (pick < 68) begin
               op = gbn_pkg::OP_ACK;
               pick = $urandom_range(9);
               if (pick < 6 && win_count > 0) begin
                  ack = 8'((win_base + $urandom_range(win_count - 1)) % SEQ_MODULUS);
                  ok  = 1'b1;
               end else if (pick >= 8) begin
                  ack = 8'($urandom_range(SEQ_MODULUS - 1));
                  ok  = 1'b1;
               end
            end else if (pick < 92) begin
               op = gbn_pkg::OP_TIMEOUT;
            end else begin
               op = OP_UNUSED;
            end
         end
         send_event(op, h, ack, ok);
         if (!(op == OP_UNUSED || (op == gbn_pkg::OP_ACK && !ok))) done++;
         if (idle_on && $urandom_range(3) == 0) pause($urandom_range(1, 8));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_events();
      test_zero_limit();
      test_pending_overflow();
      test_random_traffic(4'd8, 35, 55, 1'b1);
      test_random_traffic(4'd15, 40, 65, 1'b1);
      test_random_traffic(4'd2, 30, 55, 1'b1);
      test_random_traffic(4'd1, 35, 80, 1'b1);
      test_random_traffic(4'd0, 25, 55, 1'b0);
      test_random_traffic(4'd4, 30, 55, 1'b1);
      test_random_traffic(4'd11, 35, 55, 1'b0);

      // drain, then keep watching for stray beats
      settle_idle();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && due_wr == due_rd)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
